// File: sv/pdsc_pkg.sv
package pdsc_pkg;

    // Item kinds on the input channel.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Reset value of the mode switch interval in milliseconds.
    localparam logic [30:0] INTERVAL_RESET = 31'd2000;

    // Scale factors and offsets in hundredths.
    localparam int SPAN_W = 15;
    localparam logic [SPAN_W-1:0] TEMP_SPAN = 15'd17572;
    localparam logic [SPAN_W-1:0] HUM_SPAN  = 15'd12500;

    localparam int VAL_W = 16;
    localparam logic signed [VAL_W-1:0] TEMP_OFFSET = 16'sd4685;
    localparam logic signed [VAL_W-1:0] HUM_OFFSET  = 16'sd600;
    localparam logic signed [VAL_W-1:0] VALUE_MIN   = -16'sd4685;
    localparam logic signed [VAL_W-1:0] VALUE_MAX   = 16'sd12887;

    // The quotient never exceeds the span, so fifteen quotient bits suffice.
    localparam int QUO_W = 15;
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_TIMES,
        ST_EDGE_PERIOD,
        ST_POLL,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

// File: sv/pdsc_item_if.sv
interface pdsc_item_if;

    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] stamp_us;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output op, output stamp_us, output pin_level,
                    output now_ms, input ready);
    modport sink   (input valid, input op, input stamp_us, input pin_level,
                    input now_ms, output ready);

endinterface

// File: sv/pdsc_result_if.sv
interface pdsc_result_if;

    logic               valid;
    logic               ready;
    logic               captured;
    logic               is_temperature;
    logic signed [14:0] value_centi;
    logic               period_invalid;
    logic               select_level;

    modport source (output valid, output captured, output is_temperature,
                    output value_centi, output period_invalid, output select_level,
                    input ready);
    modport sink   (input valid, input captured, input is_temperature,
                    input value_centi, input period_invalid, input select_level,
                    output ready);

endinterface

// File: sv/pwm_duty_sensor_capture.sv
// Channel  | Direction | Handshake     | Payload
// ---------+-----------+---------------+--------------------------------------------
// item     | in        | valid / ready | op, stamp_us, pin_level, now_ms
// result   | out       | valid / ready | captured, is_temperature, value_centi,
//          |           |               | period_invalid, select_level
// cfg      | in        | cfg_wr_en     | cfg_wr_data (switch_interval_ms)
//
// An edge event occupies the block from its transfer through ST_EDGE_TIMES and ST_EDGE_PERIOD.
// A poll reporting nothing or a zero period goes from ST_POLL to ST_OUT; one that reports
// a value first multiplies, adds and runs a restoring divider giving one bit per cycle.
// Reset is asynchronous and active low; it clears all timing state and loads the interval.
// The result sits in an output register, so a stalled result only holds the block once the
// next poll has finished and needs that register.
module pwm_duty_sensor_capture (
    input  logic                 clk,
    input  logic                 rst_n,
    pdsc_item_if.sink            item,
    pdsc_result_if.source        result,
    input  logic                 cfg_wr_en,
    input  logic [30:0]          cfg_wr_data
);
    import pdsc_pkg::*;

    state_t state_reg, state_next;

    // Architectural state of the capture logic.
    logic [30:0] interval_reg,    interval_next;
    logic [31:0] rise_reg,        rise_next;
    logic [31:0] fall_reg,        fall_next;
    logic [31:0] last_fall_reg,   last_fall_next;
    logic [31:0] high_reg,        high_next;
    logic [31:0] low_reg,         low_next;
    logic [31:0] period_reg,      period_next;
    logic        capture_reg,     capture_next;
    logic        mode_temp_reg,   mode_temp_next;
    logic        switched_reg,    switched_next;
    logic [31:0] last_switch_reg, last_switch_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic                     out_cap_reg,   out_cap_next;
    logic                     out_temp_reg,  out_temp_next;
    logic signed [14:0]       out_val_reg,   out_val_next;
    logic                     out_inval_reg, out_inval_next;
    logic                     out_sel_reg,   out_sel_next;

    // Working registers of the poll sequence.
    logic [31:0]              now_reg,       now_next;
    logic                     res_cap_reg,   res_cap_next;
    logic                     res_inval_reg, res_inval_next;
    logic signed [14:0]       res_val_reg,   res_val_next;
    logic                     res_sel_reg,   res_sel_next;
    logic [46:0]              prod_reg,      prod_next;
    logic [32:0]              rem_reg,       rem_next;
    logic [QUO_W-1:0]         frac_reg,      frac_next;
    logic [QUO_W-1:0]         quo_reg,       quo_next;
    logic [CNT_W-1:0]         cnt_reg,       cnt_next;

    // Shared decisions of the poll step.
    logic [31:0] elapsed;
    logic        toggle;
    logic        report;
    logic        out_free;
    logic        item_xfer;

    // Divider step and edge arithmetic.
    logic [33:0] trial;
    logic [33:0] divisor;
    logic        trial_ge;
    logic [31:0] fall_minus_rise;
    logic [31:0] rise_minus_last;
    logic [47:0] numerator;
    logic signed [VAL_W-1:0] val_raw;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    // The mode toggles once the signed elapsed time exceeds the interval.
    assign elapsed = now_reg - last_switch_reg;
    assign toggle  = !elapsed[31] && (elapsed[30:0] > interval_reg);
    assign report  = capture_reg && (switched_reg || toggle);

    assign fall_minus_rise = fall_reg - rise_reg;
    assign rise_minus_last = rise_reg - last_fall_reg;

    // Rounded quotient of 2*H*span + P over 2*P, by restoring division.
    assign numerator = {prod_reg, 1'b0} + {16'd0, period_reg};
    assign trial     = {rem_reg, frac_reg[QUO_W-1]};
    assign divisor   = {1'b0, period_reg, 1'b0};
    assign trial_ge  = (trial >= divisor);
    assign val_raw   = $signed({1'b0, quo_reg}) - (mode_temp_reg ? TEMP_OFFSET : HUM_OFFSET);

    assign result.valid          = out_valid_reg;
    assign result.captured       = out_cap_reg;
    assign result.is_temperature = out_temp_reg;
    assign result.value_centi    = out_val_reg;
    assign result.period_invalid = out_inval_reg;
    assign result.select_level   = out_sel_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = (item.op == OP_EDGE) ? ST_EDGE_TIMES : ST_POLL;
                end
            end
            ST_EDGE_TIMES:  state_next = ST_EDGE_PERIOD;
            ST_EDGE_PERIOD: state_next = ST_IDLE;
            ST_POLL:
            begin
                state_next = (report && (period_reg != 32'd0)) ? ST_MUL : ST_OUT;
            end
            ST_MUL:         state_next = ST_ADD;
            ST_ADD:         state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:      state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // Datapath and register updates for each step.
    always_comb
    begin
        interval_next    = cfg_wr_en ? cfg_wr_data : interval_reg;
        rise_next        = rise_reg;
        fall_next        = fall_reg;
        last_fall_next   = last_fall_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        period_next      = period_reg;
        capture_next     = capture_reg;
        mode_temp_next   = mode_temp_reg;
        switched_next    = switched_reg;
        last_switch_next = last_switch_reg;

        out_valid_next   = out_valid_reg && !result.ready;
        out_cap_next     = out_cap_reg;
        out_temp_next    = out_temp_reg;
        out_val_next     = out_val_reg;
        out_inval_next   = out_inval_reg;
        out_sel_next     = out_sel_reg;

        now_next         = now_reg;
        res_cap_next     = res_cap_reg;
        res_inval_next   = res_inval_reg;
        res_val_next     = res_val_reg;
        res_sel_next     = res_sel_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        frac_next        = frac_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    if (item.op == OP_EDGE)
                    begin
                        if (item.pin_level)
                        begin
                            rise_next = item.stamp_us;
                        end
                        else
                        begin
                            fall_next = item.stamp_us;
                        end
                    end
                    else
                    begin
                        now_next = item.now_ms;
                    end
                end
            end
            ST_EDGE_TIMES:
            begin
                // Only a positive wrap-aware difference updates a time.
                if ((fall_minus_rise != 32'd0) && !fall_minus_rise[31])
                begin
                    high_next = fall_minus_rise;
                end
                if ((rise_minus_last != 32'd0) && !rise_minus_last[31])
                begin
                    low_next = rise_minus_last;
                end
            end
            ST_EDGE_PERIOD:
            begin
                period_next    = high_reg + low_reg;
                last_fall_next = fall_reg;
                capture_next   = 1'b1;
            end
            ST_POLL:
            begin
                res_sel_next   = !mode_temp_reg;
                res_cap_next   = report;
                res_inval_next = report && (period_reg == 32'd0);
                res_val_next   = '0;
                if (toggle)
                begin
                    last_switch_next = now_reg;
                    mode_temp_next   = !mode_temp_reg;
                    switched_next    = 1'b1;
                end
                if (report && (period_reg == 32'd0))
                begin
                    capture_next  = 1'b0;
                    switched_next = 1'b0;
                end
            end
            ST_MUL:
            begin
                prod_next = high_reg * (mode_temp_reg ? TEMP_SPAN : HUM_SPAN);
            end
            ST_ADD:
            begin
                rem_next  = numerator[47:QUO_W];
                frac_next = numerator[QUO_W-1:0];
                quo_next  = '0;
                cnt_next  = '0;
            end
            ST_DIV:
            begin
                rem_next  = trial_ge ? 33'(trial - divisor) : trial[32:0];
                quo_next  = {quo_reg[QUO_W-2:0], trial_ge};
                frac_next = {frac_reg[QUO_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (val_raw < VALUE_MIN)
                begin
                    res_val_next = VALUE_MIN[14:0];
                end
                else if (val_raw > VALUE_MAX)
                begin
                    res_val_next = VALUE_MAX[14:0];
                end
                else
                begin
                    res_val_next = val_raw[14:0];
                end
                capture_next  = 1'b0;
                switched_next = 1'b0;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cap_next   = res_cap_reg;
                    out_temp_next  = mode_temp_reg;
                    out_val_next   = res_val_reg;
                    out_inval_next = res_inval_reg;
                    out_sel_next   = res_sel_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            interval_reg    <= INTERVAL_RESET;
            rise_reg        <= '0;
            fall_reg        <= '0;
            last_fall_reg   <= '0;
            high_reg        <= '0;
            low_reg         <= '0;
            period_reg      <= '0;
            capture_reg     <= 1'b0;
            mode_temp_reg   <= 1'b0;
            switched_reg    <= 1'b0;
            last_switch_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            interval_reg    <= interval_next;
            rise_reg        <= rise_next;
            fall_reg        <= fall_next;
            last_fall_reg   <= last_fall_next;
            high_reg        <= high_next;
            low_reg         <= low_next;
            period_reg      <= period_next;
            capture_reg     <= capture_next;
            mode_temp_reg   <= mode_temp_next;
            switched_reg    <= switched_next;
            last_switch_reg <= last_switch_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload and working registers carry no reset.
    always_ff @(posedge clk)
    begin
        out_cap_reg   <= out_cap_next;
        out_temp_reg  <= out_temp_next;
        out_val_reg   <= out_val_next;
        out_inval_reg <= out_inval_next;
        out_sel_reg   <= out_sel_next;
        now_reg       <= now_next;
        res_cap_reg   <= res_cap_next;
        res_inval_reg <= res_inval_next;
        res_val_reg   <= res_val_next;
        res_sel_reg   <= res_sel_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        frac_reg      <= frac_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
    end

endmodule
